>>> sv/sjpg_pkg.sv
package sjpg_pkg;
	localparam int MAX_JOINTS_DEF = 16;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam logic [15:0] PERIOD_RESET = 16'd1000;
	localparam logic [4:0] JOINT_COUNT_RESET = 5'd16;

	localparam logic [2:0] ACT_TICK = 3'd0;
	localparam logic [2:0] ACT_SET = 3'd1;
	localparam logic [2:0] ACT_START = 3'd2;
	localparam logic [2:0] ACT_STOP = 3'd3;
	localparam logic [2:0] ACT_READ = 3'd4;

	localparam logic CFG_PERIOD = 1'b0;
	localparam logic CFG_COUNT = 1'b1;

	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569306;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	// Quarter-wave value at step m; evaluated at elaboration only.
	function automatic logic [15:0] quarter_wave(input int m, input int tb);
		logic [63:0] x, x2, h, r;
		x = (64'(m) << (17 - tb)) << 15;
		x2 = (x * x) >> 30;
		h = C9;
		h = C7 - ((x2 * h) >> 30);
		h = C5 - ((x2 * h) >> 30);
		h = C3 - ((x2 * h) >> 30);
		h = C1 - ((x2 * h) >> 30);
		r = (((x * h) >> 30) + 64'd16384) >> 15;
		if (r > 64'd32767)
			r = 64'd32767;
		return r[15:0];
	endfunction
endpackage

>>> sv/sinusoidal_joint_pattern_generator.sv
// A read walks ORD, R1, R2 and R3 and strobes its result from R3. A running tick first
// runs the restoring divider, then walks the joint RAM through RD, P1, SIN, P2, P3, P4
// and WB for each joint; an idle tick walks only RD and WB for each joint.
// The block takes one command at a time; set_joint, start and stop never raise busy,
// and busy drops as the last result is strobed. Results cannot stall.
// Reset clears the run state, restores period 1000 and joint count 16, then clears every
// row of the joint RAM while busy.
module sinusoidal_joint_pattern_generator #(
	parameter int MAX_JOINTS = sjpg_pkg::MAX_JOINTS_DEF,
	parameter int SINE_TABLE_BITS = sjpg_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          action,
	input  logic [15:0]         elapsed_ms,
	input  logic [3:0]          joint_index,
	input  logic signed [15:0]  amplitude,
	input  logic signed [9:0]   balance,
	input  logic signed [15:0]  phase,
	input  logic [15:0]         speed,
	input  logic signed [15:0]  center,
	input  logic signed [15:0]  scale,
	input  logic signed [1:0]   direction,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                result_valid,
	output logic [3:0]          joint_number,
	output logic signed [15:0]  angle,
	output logic signed [16:0]  servo_value,
	output logic                running,
	output logic                last
);
	import sjpg_pkg::*;

	localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int CW = $clog2(MAX_JOINTS + 1);
	localparam int TN = 1 << SINE_TABLE_BITS;
	localparam int QN = TN >> 2;
	localparam int SH = 27 - SINE_TABLE_BITS;
	localparam int RW = 74; // row: amp16 bal10 ph16 sp16 ang16

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_DIV = 4'd2,
		ST_RD = 4'd3, ST_P1 = 4'd4, ST_P2 = 4'd5, ST_P3 = 4'd6, ST_P4 = 4'd7,
		ST_WB = 4'd8, ST_ORD = 4'd9, ST_R1 = 4'd10, ST_R2 = 4'd11, ST_R3 = 4'd12,
		ST_OUT = 4'd13, ST_SIN = 4'd14;

	function automatic logic signed [15:0] sine_at(input logic [SINE_TABLE_BITS-1:0] k);
		logic [1:0] q;
		logic [SINE_TABLE_BITS-3:0] r;
		int m;
		logic [15:0] v;
		q = k[SINE_TABLE_BITS-1 -: 2];
		r = k[SINE_TABLE_BITS-3:0];
		m = q[0] ? QN - int'(r) : int'(r);
		v = quarter_wave(m, SINE_TABLE_BITS);
		return q[1] ? -$signed(v) : $signed(v);
	endfunction

	logic signed [15:0] sine_rom [TN];
	always_comb
		for (int k = 0; k < TN; k++)
			sine_rom[k] = sine_at(SINE_TABLE_BITS'(k));

	logic [RW-1:0] ram [MAX_JOINTS];
	logic [RW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we)
			ram[waddr] <= wdata;
		rd_q <= ram[raddr];
	end

	logic [3:0]  st_q;
	logic [15:0] period_q, ctime_q, elapsed_q;
	logic [4:0]  jcount_q;
	logic        run_q, stopp_q, tick_run_q;
	logic [2:0]  act_q;
	logic [3:0]  idx_q;
	logic signed [15:0] amp_q, ph_q, ctr_q, scl_q;
	logic [15:0] sp_q;
	logic signed [9:0] bal_q;
	logic signed [1:0] dir_q;
	logic [AW-1:0] j_q;
	logic [CW-1:0] n_q;
	logic [15:0] ratio_q;
	logic [31:0] rem_q;
	logic [4:0]  dcnt_q;
	logic signed [17:0] r_q;
	logic [SINE_TABLE_BITS-1:0] sidx_q;
	logic signed [15:0] sin_q;
	logic signed [31:0] prod_q;
	logic signed [31:0] a_q;
	logic signed [15:0] ang_q;
	logic signed [31:0] sprod_q;
	logic        valid_q;
	logic        valid_q_h;

	logic res_v_q, res_last_q;
	logic [3:0] res_j_q;
	logic signed [15:0] res_a_q;
	logic signed [16:0] res_s_q;

	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = res_v_q;
	assign joint_number = res_j_q;
	assign angle = res_a_q;
	assign servo_value = res_s_q;
	assign last = res_last_q;
	assign running = run_q;

	logic [CW-1:0] n_use;
	always_comb begin
		n_use = CW'(MAX_JOINTS);
		if (jcount_q != 5'd0 && 32'(jcount_q) <= MAX_JOINTS)
			n_use = CW'(jcount_q);
	end

	// tick time update
	logic [16:0] e_c, t_c;
	always_comb begin
		e_c = (elapsed_q > period_q) ? {1'b0, period_q} : {1'b0, elapsed_q};
		t_c = {1'b0, ctime_q} + e_c;
		if (t_c > {1'b0, period_q}) begin
			t_c = t_c - {1'b0, period_q};
			if (t_c > {1'b0, period_q})
				t_c = {1'b0, period_q};
		end
	end

	// row fields
	logic signed [15:0] m_amp, m_ph, m_ang;
	logic signed [9:0]  m_bal;
	logic [15:0] m_sp;
	assign {m_amp, m_bal, m_ph, m_sp, m_ang} = rd_q;

	logic signed [17:0] r_c;
	logic [33:0] pos_c;
	logic signed [31:0] bal_c, aw_c;
	logic signed [15:0] sat_c;
	logic signed [17:0] srv_c;
	logic signed [15:0] tsc_c;
	logic [31:0] drem_c;
	always_comb begin
		r_c = 18'(ratio_q) + 18'(m_ph);
		if (r_c < 0)
			r_c = r_c + 18'sd32768;
		else if (r_c > 18'sd32768)
			r_c = r_c - 18'sd32768;
		pos_c = 34'(m_sp) * 34'(r_c[16:0]);
		aw_c = prod_q / 32'sd32768;
		bal_c = 32'sd256;
		if (r_q < 18'sd16384 && bal_q > 10'sd0)
			bal_c = 32'sd256 - 32'(bal_q);
		else if (r_q > 18'sd16384 && bal_q < 10'sd0)
			bal_c = 32'sd256 + 32'(bal_q);
		sat_c = (a_q > 32'sd32767) ? 16'sh7fff :
			(a_q < -32'sd32768) ? -16'sh8000 : a_q[15:0];
		tsc_c = 16'(sprod_q / 32'sd65536);
		srv_c = 18'(ctr_q) + 18'(dir_q) * 18'(tsc_c);
		drem_c = {rem_q[30:0], 1'b0};
	end

	always_comb begin
		we = 1'b0;
		waddr = j_q;
		raddr = j_q;
		wdata = {amp_q, bal_q, ph_q, sp_q, m_ang};
		case (st_q)
			ST_CLR: begin
				we = 1'b1;
				wdata = '0;
			end
			ST_IDLE: begin
				waddr = idx_q[AW-1:0];
				raddr = joint_index[AW-1:0];
				we = (act_q == ACT_SET) && valid_q;
			end
			ST_ORD: raddr = idx_q[AW-1:0];
			ST_WB: begin
				we = tick_run_q;
				wdata = {rd_q[RW-1:16], sat_c};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			period_q <= PERIOD_RESET;
			jcount_q <= JOINT_COUNT_RESET;
			ctime_q <= '0;
			run_q <= 1'b0;
			stopp_q <= 1'b0;
			j_q <= '0;
			act_q <= ACT_STOP;
			valid_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= 1'b0;
			valid_q <= 1'b0;
			if (cfg_valid) begin
				if (cfg_index == CFG_PERIOD) begin
					if (cfg_data != 16'd0)
						period_q <= cfg_data;
				end else
					jcount_q <= cfg_data[4:0];
			end
			case (st_q)
				ST_CLR: begin
					j_q <= j_q + 1'b1;
					if (32'(j_q) == MAX_JOINTS - 1) begin
						j_q <= '0;
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: if (start) begin
					act_q <= action;
					idx_q <= joint_index;
					elapsed_q <= elapsed_ms;
					amp_q <= amplitude;
					bal_q <= balance;
					ph_q <= phase;
					sp_q <= speed;
					ctr_q <= center;
					scl_q <= scale;
					dir_q <= direction;
					n_q <= n_use;
					valid_q <= CW'(joint_index) < n_use;
					j_q <= '0;
					case (action)
						ACT_TICK: begin
							tick_run_q <= run_q;
							if (run_q) begin
								rem_q <= '0;
								dcnt_q <= '0;
								st_q <= ST_DIV;
							end else
								st_q <= ST_RD;
						end
						ACT_START: if (!run_q) begin
							run_q <= 1'b1;
							ctime_q <= '0;
							stopp_q <= 1'b0;
						end
						ACT_STOP: stopp_q <= 1'b1;
						ACT_READ: st_q <= ST_ORD;
						default: ;
					endcase
				end
				ST_DIV: begin
					// restoring divide of t<<15 by period, one bit a cycle
					if (dcnt_q == 5'd0) begin
						begin
							logic [16:0] tt;
							tt = t_c;
							if (({1'b0, ctime_q} + e_c > {1'b0, period_q}) && stopp_q) begin
								run_q <= 1'b0;
								stopp_q <= 1'b0;
								tt = '0;
							end
							ctime_q <= tt[15:0];
							rem_q <= 32'(tt);
						end
						ratio_q <= '0;
						dcnt_q <= 5'd1;
					end else begin
						// quotient bits of (t<<15)/p: first bit from t/p, then 15 shifts
						if (dcnt_q == 5'd1) begin
							if (rem_q >= 32'(period_q)) begin
								rem_q <= rem_q - 32'(period_q);
								ratio_q <= 16'd1;
							end
						end else begin
							if (drem_c >= 32'(period_q)) begin
								rem_q <= drem_c - 32'(period_q);
								ratio_q <= {ratio_q[14:0], 1'b1};
							end else begin
								rem_q <= drem_c;
								ratio_q <= {ratio_q[14:0], 1'b0};
							end
						end
						dcnt_q <= dcnt_q + 1'b1;
						if (dcnt_q == 5'd16)
							st_q <= ST_RD;
					end
				end
				ST_RD: st_q <= tick_run_q ? ST_P1 : ST_WB;
				ST_P1: begin
					r_q <= r_c;
					bal_q <= m_bal;
					sidx_q <= SINE_TABLE_BITS'(pos_c >> SH);
					st_q <= ST_SIN;
				end
				ST_SIN: begin
					sin_q <= sine_rom[sidx_q];
					st_q <= ST_P2;
				end
				ST_P2: begin
					prod_q <= 32'(m_amp) * 32'(sin_q);
					st_q <= ST_P3;
				end
				ST_P3: begin
					a_q <= aw_c;
					st_q <= ST_P4;
				end
				ST_P4: begin
					a_q <= (a_q * bal_c) / 32'sd256;
					st_q <= ST_WB;
				end
				ST_WB: begin
					logic signed [15:0] oa;
					oa = tick_run_q ? sat_c : m_ang;
					ang_q <= sat_c;
					res_v_q <= 1'b1;
					res_j_q <= 4'(j_q);
					res_a_q <= oa;
					res_s_q <= '0;
					res_last_q <= (CW'(j_q) + 1'b1 == n_q);
					if (CW'(j_q) + 1'b1 == n_q) begin
						j_q <= '0;
						st_q <= ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
						st_q <= ST_RD;
					end
				end
				ST_ORD: begin
					j_q <= idx_q[AW-1:0];
					st_q <= ST_R1;
				end
				ST_R1: begin
					ang_q <= valid_q_h ? m_ang : 16'sd0;
					st_q <= ST_R2;
				end
				ST_R2: begin
					sprod_q <= 32'(ang_q) * 32'(scl_q);
					st_q <= ST_R3;
				end
				ST_R3: begin
					res_v_q <= 1'b1;
					res_j_q <= idx_q;
					res_a_q <= ang_q;
					res_s_q <= !valid_q_h ? 17'sd0 :
						(srv_c > 18'sd65535) ? 17'sd65535 :
						(srv_c < -18'sd65536) ? -17'sd65536 : srv_c[16:0];
					res_last_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// index validity held for the read path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q_h <= 1'b0;
		else if (st_q == ST_IDLE && start)
			valid_q_h <= CW'(joint_index) < n_use;
	end
endmodule

>>> tb/tb_sinusoidal_joint_pattern_generator.sv
`timescale 1ns / 1ps

module tb_sinusoidal_joint_pattern_generator;
	import sjpg_pkg::*;

	localparam int JOINTS = 16;
	localparam int SIN_BITS = 10;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [2:0]         act;
		logic [15:0]        elapsed;
		logic [3:0]         jidx;
		logic signed [15:0] amp;
		logic signed [9:0]  bal;
		logic signed [15:0] ph;
		logic [15:0]        spd;
		logic signed [15:0] ctr;
		logic signed [15:0] scl;
		logic signed [1:0]  dir;
	} gait_cmd_t;

	typedef struct {
		logic [3:0]         num;
		logic signed [15:0] ang;
		logic signed [16:0] servo;
		logic               run;
		logic               fin;
	} joint_result_t;

	logic clk, arst_n, start, busy;
	logic [2:0] action;
	logic [15:0] elapsed_ms;
	logic [3:0] joint_index;
	logic signed [15:0] amplitude, phase, center, scale;
	logic signed [9:0] balance;
	logic [15:0] speed;
	logic signed [1:0] direction;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [15:0] cfg_data;
	logic result_valid, running, last;
	logic [3:0] joint_number;
	logic signed [15:0] angle;
	logic signed [16:0] servo_value;

	sinusoidal_joint_pattern_generator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .elapsed_ms(elapsed_ms), .joint_index(joint_index),
		.amplitude(amplitude), .balance(balance), .phase(phase), .speed(speed),
		.center(center), .scale(scale), .direction(direction),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .result_valid(result_valid),
		.joint_number(joint_number), .angle(angle), .servo_value(servo_value),
		.running(running), .last(last)
	);

	// gait state mirror
	int unsigned gait_period, gait_count;
	int unsigned gait_time;
	bit gait_run, gait_stop_req;
	longint row_amp[JOINTS], row_bal[JOINTS], row_phase[JOINTS], row_speed[JOINTS];
	longint row_angle[JOINTS];
	longint sine_lut[1 << SIN_BITS];
	joint_result_t pending_results[$];
	int errors = 0;
	int stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint quarter_sine(int m);
		logic [63:0] x, xx, poly, res;
		x = (64'(m) << (17 - SIN_BITS)) << 15;
		xx = (x * x) >> 30;
		poly = 64'd172272;
		poly = 64'd5026995 - ((xx * poly) >> 30);
		poly = 64'd85569306 - ((xx * poly) >> 30);
		poly = 64'd693598668 - ((xx * poly) >> 30);
		poly = 64'd1686629713 - ((xx * poly) >> 30);
		res = (((x * poly) >> 30) + 64'd16384) >> 15;
		if (res > 64'd32767)
			res = 64'd32767;
		return longint'(res);
	endfunction

	function automatic void build_sine_lut();
		int qn, quad, off;
		longint v;
		qn = (1 << SIN_BITS) / 4;
		for (int k = 0; k < (1 << SIN_BITS); k++) begin
			quad = k / qn;
			off = k % qn;
			v = quarter_sine((quad & 1) ? qn - off : off);
			sine_lut[k] = (quad & 2) ? -v : v;
		end
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned joints_active();
		return (gait_count == 0 || gait_count > JOINTS) ? JOINTS : gait_count;
	endfunction

	function automatic void gait_reset();
		gait_period = 32'(PERIOD_RESET);
		gait_count = 32'(JOINT_COUNT_RESET);
		gait_time = 0;
		gait_run = 0;
		gait_stop_req = 0;
		for (int i = 0; i < JOINTS; i++) begin
			row_amp[i] = 0; row_bal[i] = 0; row_phase[i] = 0;
			row_speed[i] = 0; row_angle[i] = 0;
		end
	endfunction

	function automatic void advance_gait(logic [15:0] elapsed);
		int unsigned e, t;
		longint ratio, r, a, pos;
		e = 32'(elapsed);
		if (e > gait_period)
			e = gait_period;
		t = gait_time + e;
		if (t > gait_period) begin
			t -= gait_period;
			if (t > gait_period)
				t = gait_period;
			if (gait_stop_req) begin
				gait_run = 0;
				gait_stop_req = 0;
				t = 0;
			end
		end
		gait_time = t;
		ratio = (longint'(t) << 15) / gait_period;
		for (int i = 0; i < joints_active(); i++) begin
			r = ratio + row_phase[i];
			if (r < 0)
				r += 32768;
			else if (r > 32768)
				r -= 32768;
			pos = (row_speed[i] * r) >>> (27 - SIN_BITS);
			a = row_amp[i] * sine_lut[pos % (1 << SIN_BITS)] / 32768;
			if (r < 16384 && row_bal[i] > 0)
				a = a * (256 - row_bal[i]) / 256;
			else if (r > 16384 && row_bal[i] < 0)
				a = a * (256 + row_bal[i]) / 256;
			row_angle[i] = clamp(a, -32768, 32767);
		end
	endfunction

	function automatic void predict_cmd(gait_cmd_t c);
		joint_result_t res;
		int unsigned n;
		longint ang, servo;
		n = joints_active();
		case (c.act)
			ACT_TICK: begin
				if (gait_run)
					advance_gait(c.elapsed);
				for (int i = 0; i < n; i++) begin
					res.num = 4'(i);
					res.ang = 16'(row_angle[i]);
					res.servo = '0;
					res.run = gait_run;
					res.fin = (i + 1 == n);
					pending_results.push_back(res);
				end
			end
			ACT_SET: begin
				if (c.jidx < n) begin
					row_amp[c.jidx] = longint'(c.amp);
					row_bal[c.jidx] = longint'(c.bal);
					row_phase[c.jidx] = longint'(c.ph);
					row_speed[c.jidx] = longint'(c.spd);
				end
			end
			ACT_START: begin
				if (!gait_run) begin
					gait_run = 1;
					gait_time = 0;
					gait_stop_req = 0;
				end
			end
			ACT_STOP: gait_stop_req = 1;
			ACT_READ: begin
				ang = 0;
				servo = 0;
				if (c.jidx < n) begin
					ang = row_angle[c.jidx];
					servo = clamp(longint'(c.ctr) + longint'(c.dir) *
						((ang * longint'(c.scl)) / 65536), -65536, 65535);
				end
				res.num = c.jidx;
				res.ang = 16'(ang);
				res.servo = 17'(servo);
				res.run = gait_run;
				res.fin = 1'b1;
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic gait_cmd_t random_cmd(logic [2:0] act);
		gait_cmd_t c;
		c.act = act;
		c.elapsed = 16'($urandom);
		c.jidx = 4'($urandom);
		c.amp = 16'($urandom);
		c.bal = 10'($urandom);
		c.ph = 16'($urandom);
		c.spd = 16'($urandom);
		c.ctr = 16'($urandom);
		c.scl = 16'($urandom);
		c.dir = 2'($urandom);
		return c;
	endfunction

	// Leaves start high after the transfer; the next call lowers it if it idles.
	task automatic send_cmd(gait_cmd_t c);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= c.act;
		elapsed_ms <= c.elapsed;
		joint_index <= c.jidx;
		amplitude <= c.amp;
		balance <= c.bal;
		phase <= c.ph;
		speed <= c.spd;
		center <= c.ctr;
		scale <= c.scl;
		direction <= c.dir;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		predict_cmd(c);
	endtask

	task automatic send_op(logic [2:0] act);
		send_cmd(random_cmd(act));
	endtask

	task automatic send_tick(logic [15:0] elapsed);
		gait_cmd_t c;
		c = random_cmd(ACT_TICK);
		c.elapsed = elapsed;
		send_cmd(c);
	endtask

	task automatic send_read(logic [3:0] j);
		gait_cmd_t c;
		c = random_cmd(ACT_READ);
		c.jidx = j;
		send_cmd(c);
	endtask

	task automatic set_row(logic [3:0] j, logic signed [15:0] a, logic signed [9:0] b,
			logic signed [15:0] p, logic [15:0] s);
		gait_cmd_t c;
		c = random_cmd(ACT_SET);
		c.jidx = j; c.amp = a; c.bal = b; c.ph = p; c.spd = s;
		send_cmd(c);
	endtask

	// Drop start and let the block go quiet before touching registers.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		settle();
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_PERIOD) begin
			if (data != 0)
				gait_period = 32'(data);
		end else begin
			gait_count = 32'(data[4:0]);
		end
	endtask

	always @(posedge clk) begin
		joint_result_t exp_r;
		if (arst_n && result_valid) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result for joint %0d", joint_number);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (joint_number !== exp_r.num) begin
					$error("joint_number exp %0d got %0d", exp_r.num, joint_number);
					errors++;
				end
				if (angle !== exp_r.ang) begin
					$error("angle exp %0d got %0d", exp_r.ang, angle);
					errors++;
				end
				if (servo_value !== exp_r.servo) begin
					$error("servo_value exp %0d got %0d", exp_r.servo, servo_value);
					errors++;
				end
				if (running !== exp_r.run) begin
					$error("running exp %0d got %0d", exp_r.run, running);
					errors++;
				end
				if (last !== exp_r.fin) begin
					$error("last exp %0d got %0d", exp_r.fin, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic test_reset_state();
		send_read(4'd0);
		send_read(4'd15);
		send_tick(16'd500);
		send_op(3'd5);
		send_op(3'd6);
		send_op(3'd7);
	endtask

	task automatic test_joint_extremes();
		set_row(4'd0, 16'sh7FFF, 10'sd256, 16'sh7FFF, 16'hFFFF);
		set_row(4'd1, -16'sh8000, -10'sd256, -16'sh8000, 16'h1000);
		set_row(4'd2, 16'sh1234, -10'sd512, 16'sh4000, 16'h0800);
		set_row(4'd3, -16'sh2000, 10'sd511, -16'sh0001, 16'h3000);
		send_op(ACT_STOP);
		send_op(ACT_START);
		send_tick(16'd0);
		send_tick(16'd250);
		send_tick(16'hFFFF);
		send_op(ACT_START);
		send_tick(16'd999);
		for (int j = 0; j < 4; j++)
			send_read(j[3:0]);
	endtask

	task automatic test_stop_at_wrap();
		send_op(ACT_STOP);
		send_tick(16'd400);
		send_tick(16'd700);
		send_tick(16'd100);
	endtask

	task automatic test_registers();
		write_reg(CFG_COUNT, 16'd3);
		send_read(4'd3);
		send_read(4'd2);
		set_row(4'd5, 16'sh1111, 10'sd0, 16'sd0, 16'h1000);
		write_reg(CFG_PERIOD, 16'd0);
		write_reg(CFG_COUNT, 16'd0);
		send_op(ACT_START);
		send_tick(16'd900);
		// shrink the period under a running cycle time to force the clamp
		write_reg(CFG_PERIOD, 16'd100);
		send_tick(16'd100);
		write_reg(CFG_PERIOD, 16'd65535);
		write_reg(CFG_COUNT, 16'd31);
		send_tick(16'd65535);
		write_reg(CFG_PERIOD, 16'd1);
		write_reg(CFG_COUNT, 16'd1);
		send_tick(16'd1);
		send_tick(16'd2);
		send_read(4'd0);
	endtask

	task automatic random_phase(logic [15:0] per, logic [15:0] cnt, int items);
		int sel;
		write_reg(CFG_PERIOD, per);
		write_reg(CFG_COUNT, cnt);
		for (int i = 0; i < items; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				if ($urandom_range(0, 3) == 0)
					send_tick(16'($urandom));
				else
					send_tick(16'($urandom_range(0, per / 3 + 1)));
			end else if (sel < 65)
				send_op(ACT_SET);
			else if (sel < 85)
				send_op(ACT_READ);
			else if (sel < 91)
				send_op(ACT_START);
			else if (sel < 96)
				send_op(ACT_STOP);
			else
				send_op(3'($urandom_range(5, 7)));
		end
	endtask

	task automatic test_random();
		send_op(ACT_START);
		random_phase(16'd1000, 16'd16, 75);
		random_phase(16'd37, 16'd5, 80);
		random_phase(16'd1, 16'd1, 40);
		random_phase(16'd65535, 16'd0, 60);
		random_phase(16'd250, 16'd9, 40);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_TICK;
		elapsed_ms = '0;
		joint_index = '0;
		amplitude = '0;
		balance = '0;
		phase = '0;
		speed = '0;
		center = '0;
		scale = '0;
		direction = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PERIOD;
		cfg_data = '0;
		build_sine_lut();
		gait_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_joint_extremes();
		test_stop_at_wrap();
		test_registers();
		test_random();

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
